### hw/rtl/palette_index_rle_encoder_top_defines.svh
// Assertion macros shared by the encoder RTL.
`ifndef PALETTE_INDEX_RLE_ENCODER_TOP_DEFINES_SVH
`define PALETTE_INDEX_RLE_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define PIRE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define PIRE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define PIRE_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PIRE_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/pire_pkg.sv
package pire_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_EMIT
   } state_type;

   localparam logic       ACTION_LOAD  = 1'b0;
   localparam logic       ACTION_PIXEL = 1'b1;

   // Register index as decoded from the byte address.
   localparam logic       CSR_IDX_PALETTE_SIZE = 1'b0;

   localparam logic [7:0]  SHORT_MARK = 8'hFF;
   localparam logic [7:0]  LONG_MARK  = 8'hFE;
   localparam logic [7:0]  MISS_BYTE  = 8'hFF;
   localparam logic [15:0] RUN_LIMIT  = 16'hFFFF;
   localparam logic [15:0] SHORT_RUN_END = 16'd256;

   typedef struct packed {
      logic [1:0]      cnt;
      logic [2:0][7:0] bytes;
   } flush_type;

   // Bytes that flush a pending run: none, a short marker plus count, or a
   // long marker plus the count's low and high bytes.
   function automatic flush_type run_flush(input logic [15:0] run);
      flush_type f;
      f.cnt   = 2'd0;
      f.bytes = '0;
      if (run == 16'd0) begin
         f.cnt = 2'd0;
      end else if (run < SHORT_RUN_END) begin
         f.cnt      = 2'd2;
         f.bytes[0] = SHORT_MARK;
         f.bytes[1] = run[7:0];
      end else begin
         f.cnt      = 2'd3;
         f.bytes[0] = LONG_MARK;
         f.bytes[1] = run[7:0];
         f.bytes[2] = run[15:8];
      end
      return f;
   endfunction

endpackage

### hw/rtl/pire_req_if.sv
interface pire_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [7:0]  palette_slot;
   logic [15:0] palette_color;
   logic [15:0] pixel_color;
   logic        end_of_image;

   modport source (
      output valid, action, palette_slot, palette_color, pixel_color, end_of_image,
      input  ready
   );

   modport sink (
      input  valid, action, palette_slot, palette_color, pixel_color, end_of_image,
      output ready
   );
endinterface

### hw/rtl/pire_rsp_if.sv
interface pire_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       last_of_item;

   modport source (
      output valid, stream_byte, last_of_item,
      input  ready
   );

   modport sink (
      input  valid, stream_byte, last_of_item,
      output ready
   );
endinterface

### hw/rtl/pire_ram.sv
module pire_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/palette_index_rle_encoder_top.sv
// Channel   Direction  Handshake      Words per item
// req_chan  in         valid / ready  one word: a palette load or a pixel
// rsp_chan  out        valid / ready  zero to four stream bytes per word
// APB csr   in         psel / penable one register write, no wait states
//
// A palette load produces no output.
// A pixel occupies the block from its word to the next for longer when its color is
// missing than on a hit, and longer for each emitted byte; the linear search through
// the single read port of the palette RAM, one compare a cycle, sets it.
// req_chan is ready only while idle; rsp_chan stalls simply hold the byte.
// Reset is synchronous; the palette RAM is not cleared and needs no sweep.
`include "palette_index_rle_encoder_top_defines.svh"

module palette_index_rle_encoder_top #(
   parameter int PALETTE_DEPTH = 256
) (
   input  logic        clock,
   input  logic        reset,
   pire_req_if.sink    req_chan,
   pire_rsp_if.source  rsp_chan,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // Index width for the palette, and a width that can also hold the depth.
   localparam int IW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int LW = $clog2(PALETTE_DEPTH + 1);
   localparam logic [8:0]    DEPTH_SIZE  = 9'(PALETTE_DEPTH);
   localparam logic [LW-1:0] DEPTH_LIMIT = LW'(PALETTE_DEPTH);

   pire_pkg::state_type state_ff, state_in;

   // Configuration and sequencer registers.
   logic [8:0]      size_ff, size_in;
   logic [LW-1:0]   limit_ff, limit_in;
   logic [LW-1:0]   iss_ff, iss_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [IW-1:0]   cmp_idx_ff, cmp_idx_in;

   // Pixel being encoded and the result of its search.
   logic [15:0]     color_ff, color_in;
   logic            eoi_ff, eoi_in;
   logic            res_miss_ff, res_miss_in;
   logic [IW-1:0]   res_idx_ff, res_idx_in;

   // Encoder state: the previous index is either "missing" or a palette index.
   logic            prev_miss_ff, prev_miss_in;
   logic [IW-1:0]   prev_idx_ff, prev_idx_in;
   logic [15:0]     run_ff, run_in;

   // Output byte buffer for the current pixel.
   logic [3:0][7:0] buf_ff, buf_in;
   logic [1:0]      last_ff, last_in;
   logic [1:0]      ptr_ff, ptr_in;

   // Combinational helpers.
   logic            cfg_write;
   logic            pal_wr_en;
   logic            pal_rd_en;
   logic [15:0]     pal_rd_data;
   logic [LW-1:0]   size_limit;
   logic            same_idx;
   logic [7:0]      idx_byte;
   logic [15:0]     run_inc;
   logic [2:0]      byte_cnt;
   pire_pkg::flush_type fl_old;
   pire_pkg::flush_type fl_new;

   // A write lands on the access cycle of an APB transfer.
   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == pire_pkg::CSR_IDX_PALETTE_SIZE) ? {23'd0, size_ff} : 32'd0;

   // Sizes above the palette depth search the whole palette.
   assign size_limit = (size_ff > DEPTH_SIZE) ? DEPTH_LIMIT : LW'(size_ff);

   // Loads go straight into the palette RAM when accepted; slots past the
   // depth are dropped.
   assign pal_wr_en = (state_ff == pire_pkg::ST_IDLE) && req_chan.valid
                      && (req_chan.action == pire_pkg::ACTION_LOAD)
                      && (9'(req_chan.palette_slot) < DEPTH_SIZE);

   pire_ram #(
      .WIDTH (16),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_chan.palette_slot[IW-1:0]),
      .wr_data (req_chan.palette_color),
      .rd_en   (pal_rd_en),
      .rd_addr (iss_ff[IW-1:0]),
      .rd_data (pal_rd_data)
   );

   // Decision logic for one pixel once its index is known.
   assign same_idx = (res_miss_ff == prev_miss_ff) && (res_miss_ff || (res_idx_ff == prev_idx_ff));
   assign idx_byte = res_miss_ff ? pire_pkg::MISS_BYTE : 8'(res_idx_ff);
   assign run_inc  = run_ff + 16'd1;
   assign fl_old   = pire_pkg::run_flush(run_ff);
   assign fl_new   = pire_pkg::run_flush(run_inc);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pire_pkg::ST_IDLE;
         size_ff      <= 9'd0;
         cmp_valid_ff <= 1'b0;
         prev_miss_ff <= 1'b1;
         prev_idx_ff  <= '0;
         run_ff       <= 16'd0;
         ptr_ff       <= 2'd0;
         last_ff      <= 2'd0;
      end else begin
         state_ff     <= state_in;
         size_ff      <= size_in;
         cmp_valid_ff <= cmp_valid_in;
         prev_miss_ff <= prev_miss_in;
         prev_idx_ff  <= prev_idx_in;
         run_ff       <= run_in;
         ptr_ff       <= ptr_in;
         last_ff      <= last_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      limit_ff    <= limit_in;
      iss_ff      <= iss_in;
      cmp_idx_ff  <= cmp_idx_in;
      color_ff    <= color_in;
      eoi_ff      <= eoi_in;
      res_miss_ff <= res_miss_in;
      res_idx_ff  <= res_idx_in;
      buf_ff      <= buf_in;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      limit_in     = limit_ff;
      iss_in       = iss_ff;
      cmp_valid_in = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      color_in     = color_ff;
      eoi_in       = eoi_ff;
      res_miss_in  = res_miss_ff;
      res_idx_in   = res_idx_ff;
      prev_miss_in = prev_miss_ff;
      prev_idx_in  = prev_idx_ff;
      run_in       = run_ff;
      buf_in       = buf_ff;
      last_in      = last_ff;
      ptr_in       = ptr_ff;
      byte_cnt     = 3'd0;
      pal_rd_en    = 1'b0;

      req_chan.ready        = 1'b0;
      rsp_chan.valid        = 1'b0;
      rsp_chan.stream_byte  = buf_ff[ptr_ff];
      rsp_chan.last_of_item = (ptr_ff == last_ff);

      if (cfg_write && (paddr[2] == pire_pkg::CSR_IDX_PALETTE_SIZE)) begin
         size_in = pwdata[8:0];
      end

      case (state_ff)
         pire_pkg::ST_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid && (req_chan.action == pire_pkg::ACTION_PIXEL)) begin
               color_in = req_chan.pixel_color;
               eoi_in   = req_chan.end_of_image;
               limit_in = size_limit;
               iss_in   = '0;
               state_in = pire_pkg::ST_SEARCH;
            end
         end

         pire_pkg::ST_SEARCH: begin
            // Reads are issued one entry a cycle; each compare sees the data
            // of the address issued the cycle before.
            pal_rd_en    = (iss_ff < limit_ff);
            cmp_valid_in = pal_rd_en;
            cmp_idx_in   = iss_ff[IW-1:0];
            if (pal_rd_en) begin
               iss_in = iss_ff + LW'(1);
            end
            if (cmp_valid_ff && (pal_rd_data == color_ff)) begin
               res_miss_in  = 1'b0;
               res_idx_in   = cmp_idx_ff;
               cmp_valid_in = 1'b0;
               state_in     = pire_pkg::ST_DECIDE;
            end else if (!cmp_valid_ff && (iss_ff == limit_ff)) begin
               res_miss_in = 1'b1;
               state_in    = pire_pkg::ST_DECIDE;
            end
         end

         pire_pkg::ST_DECIDE: begin
            buf_in = '0;
            if (!same_idx) begin
               // A new index flushes the pending run, then emits its byte.
               buf_in[2:0]        = fl_old.bytes;
               buf_in[fl_old.cnt] = idx_byte;
               byte_cnt           = {1'b0, fl_old.cnt} + 3'd1;
               prev_miss_in       = res_miss_ff;
               prev_idx_in        = res_idx_ff;
               run_in             = 16'd0;
            end else if (run_inc == pire_pkg::RUN_LIMIT) begin
               // A saturated run flushes at once and forgets the index.
               buf_in[0]    = pire_pkg::LONG_MARK;
               buf_in[1]    = pire_pkg::RUN_LIMIT[7:0];
               buf_in[2]    = pire_pkg::RUN_LIMIT[15:8];
               byte_cnt     = 3'd3;
               run_in       = 16'd0;
               prev_miss_in = 1'b1;
            end else begin
               run_in = run_inc;
               if (eoi_ff) begin
                  buf_in[2:0] = fl_new.bytes;
                  byte_cnt    = {1'b0, fl_new.cnt};
               end
            end
            if (eoi_ff) begin
               prev_miss_in = 1'b1;
               run_in       = 16'd0;
            end
            ptr_in  = 2'd0;
            last_in = 2'(byte_cnt - 3'd1);
            if (byte_cnt == 3'd0) begin
               state_in = pire_pkg::ST_IDLE;
            end else begin
               state_in = pire_pkg::ST_EMIT;
            end
         end

         pire_pkg::ST_EMIT: begin
            rsp_chan.valid = 1'b1;
            if (rsp_chan.ready) begin
               ptr_in = ptr_ff + 2'd1;
               if (ptr_ff == last_ff) begin
                  state_in = pire_pkg::ST_IDLE;
               end
            end
         end

         default: begin
            state_in = pire_pkg::ST_IDLE;
         end
      endcase
   end

   // Input and output sides never overlap: a word is taken only while idle.
   `PIRE_ASSERT_NOW(a_ready_excl_valid, clock, reset, req_chan.ready, !rsp_chan.valid)

   // The last byte of an item hands control back to the input side.
   `PIRE_ASSERT_NEXT(a_last_to_idle, clock, reset,
      rsp_chan.valid && rsp_chan.ready && rsp_chan.last_of_item, req_chan.ready)

   // The run counter is cleared before it can hold the saturation value.
   `PIRE_ASSERT_NOW(a_run_below_limit, clock, reset, 1'b1, run_ff != pire_pkg::RUN_LIMIT)

   // Every compare looks at an entry inside the searched range.
   `PIRE_ASSERT_NOW(a_cmp_in_range, clock, reset,
      cmp_valid_ff, (LW'(cmp_idx_ff) < limit_ff) && (state_ff == pire_pkg::ST_SEARCH))

endmodule

### verif/tb_top.sv
module tb_top;

   // The block is built with its default palette depth, and the encoding model
   // below uses the same depth.
   localparam int          PALETTE_DEPTH     = 256;
   localparam logic [15:0] NO_INDEX          = 16'hFFFF;
   localparam logic [2:0]  PALETTE_SIZE_ADDR = {pire_pkg::CSR_IDX_PALETTE_SIZE, 2'b00};
   // A pixel whose color is missing from a full palette keeps the block busy
   // through its whole search without producing a byte. Every quiet period is
   // longer than that search.
   localparam int          SETTLE_CYCLES     = 300;
   // The limit is well above the time that all words here and the quiet
   // periods take together, even under the heaviest stalls.
   localparam int          CYCLE_LIMIT       = 200_000;
   localparam int          REPORT_LIMIT      = 10;
   localparam int          RANDOM_WORDS      = 16;

   // One input word: a palette load or a pixel.
   typedef struct packed {
      logic        action;
      logic [7:0]  palette_slot;
      logic [15:0] palette_color;
      logic [15:0] pixel_color;
      logic        end_of_image;
   } req_word_type;

   // One output word: a byte of the encoded stream.
   typedef struct packed {
      logic [7:0] stream_byte;
      logic       last_of_item;
   } stream_word_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   pire_req_if req_bus ();
   pire_rsp_if rsp_bus ();

   palette_index_rle_encoder_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // The encoder state as the testbench tracks it. Palette entries are only
   // read after they have been loaded, so the array needs no clearing.
   logic [15:0]     palette_model [PALETTE_DEPTH];
   logic [15:0]     last_index;
   logic [15:0]     run_length;
   logic [8:0]      size_setting;
   logic [7:0]      step_bytes [$];
   stream_word_type expected_stream [$];
   logic [15:0]     last_pixel;

   int sender_idle_pct;
   int receiver_stall_pct;
   int failures;
   int cycle_count;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Counts a failure and prints the first few of them.
   task automatic note_failure(input string what, input logic [31:0] want,
                               input logic [31:0] got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("mismatch (%s) at cycle %0d: expected %0h, got %0h",
                  what, cycle_count, want, got);
      end
   endtask

   // Appends the bytes that close the pending run. A run below 256 uses the
   // short marker and one count byte; longer runs use the long marker and
   // the count in little-endian order.
   task automatic flush_pending_run();
      if (run_length == 16'd0) return;
      if (run_length < 16'd256) begin
         step_bytes.push_back(pire_pkg::SHORT_MARK);
         step_bytes.push_back(run_length[7:0]);
      end else begin
         step_bytes.push_back(pire_pkg::LONG_MARK);
         step_bytes.push_back(run_length[7:0]);
         step_bytes.push_back(run_length[15:8]);
      end
      run_length = 16'd0;
   endtask

   // Applies one accepted word to the encoder state and queues the stream
   // bytes that it should produce, the last one flagged.
   task automatic predict_encoding(input req_word_type w);
      int          limit;
      logic [15:0] lookup_index;
      bit          found;
      step_bytes.delete();
      if (w.action == pire_pkg::ACTION_LOAD) begin
         if (w.palette_slot < PALETTE_DEPTH) palette_model[w.palette_slot] = w.palette_color;
         return;
      end
      limit = (size_setting > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_setting);
      lookup_index = NO_INDEX;
      found = 1'b0;
      for (int i = 0; i < limit; i++) begin
         if (!found && palette_model[i] == w.pixel_color) begin
            lookup_index = 16'(i);
            found = 1'b1;
         end
      end
      if (lookup_index != last_index) begin
         flush_pending_run();
         step_bytes.push_back(lookup_index[7:0]);
         last_index = lookup_index;
      end else begin
         run_length = run_length + 16'd1;
      end
      // A run that reaches the counter's limit is flushed at once and the
      // index history is forgotten.
      if (run_length == pire_pkg::RUN_LIMIT) begin
         step_bytes.push_back(pire_pkg::LONG_MARK);
         step_bytes.push_back(8'hFF);
         step_bytes.push_back(8'hFF);
         run_length = 16'd0;
         last_index = NO_INDEX;
      end
      if (w.end_of_image) begin
         flush_pending_run();
         last_index = NO_INDEX;
         run_length = 16'd0;
      end
      foreach (step_bytes[k]) begin
         expected_stream.push_back({step_bytes[k], (k == step_bytes.size() - 1)});
      end
   endtask

   // Builders for the two kinds of word. The fields that an action ignores
   // carry random values so that the block is seen to ignore them.
   function automatic req_word_type load_word(input logic [7:0] slot, input logic [15:0] color);
      req_word_type w;
      w.action        = pire_pkg::ACTION_LOAD;
      w.palette_slot  = slot;
      w.palette_color = color;
      w.pixel_color   = 16'($urandom);
      w.end_of_image  = 1'($urandom);
      return w;
   endfunction

   function automatic req_word_type pixel_word(input logic [15:0] color, input logic eoi);
      req_word_type w;
      w.action        = pire_pkg::ACTION_PIXEL;
      w.palette_slot  = 8'($urandom);
      w.palette_color = 16'($urandom);
      w.pixel_color   = color;
      w.end_of_image  = eoi;
      return w;
   endfunction

   // Random traffic is mostly pixels. Many repeat the previous color to build
   // runs, many take a color from the searched part of the palette so that
   // they hit, and the rest are random colors that mostly miss.
   function automatic req_word_type random_word();
      int          roll  = $urandom_range(99);
      int          limit = (size_setting > PALETTE_DEPTH) ? PALETTE_DEPTH : int'(size_setting);
      logic [15:0] color;
      if (roll < 10) return load_word(8'($urandom), 16'($urandom));
      if (roll < 45) begin
         color = last_pixel;
      end else if (roll < 88 && limit > 0) begin
         color = palette_model[$urandom_range(limit - 1)];
      end else begin
         color = 16'($urandom);
      end
      last_pixel = color;
      return pixel_word(color, $urandom_range(99) < 6);
   endfunction

   // Presents one word and holds it until it is accepted. The task is
   // entered and left at a falling edge, and valid stays high on return so
   // that back-to-back words never drop it for a cycle.
   task automatic send_word(input req_word_type w);
      while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.action        <= w.action;
      req_bus.palette_slot  <= w.palette_slot;
      req_bus.palette_color <= w.palette_color;
      req_bus.pixel_color   <= w.pixel_color;
      req_bus.end_of_image  <= w.end_of_image;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_encoding(w);
      @(negedge clock);
   endtask

   // Stops sending, waits for every predicted byte, and then lets a silent
   // pixel search run out before anything else happens.
   task automatic drain_and_settle();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (expected_stream.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes palette_size over the register port once the block is idle, then
   // reads it back.
   task automatic write_palette_size(input logic [8:0] value);
      drain_and_settle();
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PALETTE_SIZE_ADDR;
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      size_setting = value;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== 32'(value)) note_failure("palette_size readback", 32'(value), prdata);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Right after reset the size is zero, so every pixel misses. Because the
   // index history starts out as "missing", the first miss already counts as
   // a repeat and no index byte is sent; the end of the image flushes the run.
   task automatic test_reset_misses();
      send_word(pixel_word(16'($urandom), 1'b0));
      send_word(pixel_word(16'($urandom), 1'b0));
      send_word(pixel_word(16'($urandom), 1'b1));
   endtask

   // A small palette with the extreme colors and a duplicate entry, so that
   // the first match wins. Loads also reach the top slot. The pixels walk
   // through a hit, a repeat, an index change, a repeat through the
   // duplicate, a miss and a repeated miss, and an image end on a hit.
   task automatic test_palette_lookup();
      send_word(load_word(8'd0, 16'h0000));
      send_word(load_word(8'd1, 16'hFFFF));
      send_word(load_word(8'd2, 16'h1234));
      send_word(load_word(8'd3, 16'hFFFF));
      send_word(load_word(8'd255, 16'hA5A5));
      write_palette_size(9'd4);
      send_word(pixel_word(16'h0000, 1'b0));
      send_word(pixel_word(16'h0000, 1'b0));
      send_word(pixel_word(16'hFFFF, 1'b0));
      send_word(pixel_word(16'hFFFF, 1'b0));
      send_word(pixel_word(16'h1234, 1'b0));
      send_word(pixel_word(16'hBEEF, 1'b0));
      send_word(pixel_word(16'hBEEF, 1'b0));
      send_word(pixel_word(16'hA5A5, 1'b0));
      send_word(pixel_word(16'h1234, 1'b1));
   endtask

   // A run just past the short/long boundary: one index byte, then 256
   // repeats that the image end flushes in the long form.
   task automatic test_run_boundaries();
      sender_idle_pct    = 33;
      receiver_stall_pct = 33;
      for (int n = 0; n < 257; n++) send_word(pixel_word(16'h1234, n == 256));
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
   endtask

   // Four phases of random words, one per idling pattern, each under its own
   // palette size within the loaded entries. Halfway through the
   // receiver-stall phase the sender waits until the stream has fully drained.
   task automatic test_random_traffic();
      logic [8:0] new_size;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               new_size = 9'd4;
               sender_idle_pct = 0;  receiver_stall_pct = 0;
            end
            1: begin
               new_size = 9'd1;
               sender_idle_pct = 46; receiver_stall_pct = 0;
            end
            2: begin
               new_size = 9'($urandom_range(4, 2));
               sender_idle_pct = 0;  receiver_stall_pct = 46;
            end
            default: begin
               new_size = 9'($urandom_range(4));
               sender_idle_pct = 33; receiver_stall_pct = 33;
            end
         endcase
         write_palette_size(new_size);
         for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (phase == 2 && n == RANDOM_WORDS / 2) drain_and_settle();
            send_word(random_word());
         end
      end
   endtask

   // The receiver decides at each falling edge whether it takes a word at the
   // next rising edge.
   always @(negedge clock) begin
      rsp_bus.ready <= (receiver_stall_pct == 0) ||
                       ($urandom_range(99) >= receiver_stall_pct);
   end

   // Every word accepted on the result channel is compared with the oldest
   // predicted byte, field by field.
   always @(posedge clock) begin
      stream_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_stream.size() == 0) begin
            note_failure("byte with nothing pending", 32'd0, 32'(rsp_bus.stream_byte));
         end else begin
            want = expected_stream.pop_front();
            if (rsp_bus.stream_byte !== want.stream_byte) begin
               note_failure("stream_byte", 32'(want.stream_byte), 32'(rsp_bus.stream_byte));
            end
            if (rsp_bus.last_of_item !== want.last_of_item) begin
               note_failure("last_of_item", 32'(want.last_of_item),
                            32'(rsp_bus.last_of_item));
            end
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_bus.valid         = 1'b0;
      req_bus.action        = pire_pkg::ACTION_LOAD;
      req_bus.palette_slot  = '0;
      req_bus.palette_color = '0;
      req_bus.pixel_color   = '0;
      req_bus.end_of_image  = 1'b0;
      rsp_bus.ready         = 1'b0;
      sender_idle_pct       = 0;
      receiver_stall_pct    = 0;
      failures              = 0;
      cycle_count           = 0;
      last_index            = NO_INDEX;
      run_length            = 16'd0;
      size_setting          = 9'd0;
      last_pixel            = 16'h0000;

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_misses();
      test_palette_lookup();
      test_run_boundaries();
      test_random_traffic();

      // Everything sent; wait for the tail of the stream and a quiet period
      // in which no stray byte may appear.
      drain_and_settle();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
